>>> sv/bwfa_pkg.sv
// ----------------------------------------------------------------------------
// bwfa_pkg
// Shared types, widths and codes of the best/worst fit segment allocator.
// ----------------------------------------------------------------------------
package bwfa_pkg;

    localparam int MAX_SEG   = 64;
    localparam int IDX_W     = $clog2(MAX_SEG);
    localparam int CNT_W     = IDX_W + 1;
    localparam int OFF_W     = 16;
    localparam int LEN_W     = 17;
    localparam int BYTES_W   = 21;
    localparam int WB_W      = 5;
    localparam int DIVD_W    = BYTES_W + 1;
    localparam int DIV_STEPS = DIVD_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int PADDR_W   = 4;

    localparam logic [LEN_W-1:0] WORD_LIMIT = 17'd65536;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOFIT     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] REG_WORD_BYTES  = 2'd0;
    localparam logic [1:0] REG_TOTAL_WORDS = 2'd1;
    localparam logic [1:0] REG_FIT_MODE    = 2'd2;

    typedef struct packed {
        logic [OFF_W-1:0] start;
        logic [LEN_W-1:0] len;
        logic             used;
    } seg_t;

    typedef struct packed {
        logic               cmd;
        logic [BYTES_W-1:0] size_bytes;
        logic [OFF_W-1:0]   offset_words;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [OFF_W-1:0] result_offset;
    } rsp_t;

    typedef struct packed {
        logic             start;
        logic             cmd;
        logic [LEN_W-1:0] words;
        logic [OFF_W-1:0] off;
        logic             fit_mode;
    } tbl_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [1:0]       status;
        logic [OFF_W-1:0] offset;
    } tbl_rsp_t;

endpackage

>>> sv/bwfa_div.sv
// ----------------------------------------------------------------------------
// bwfa_div
// Restoring divider, one quotient bit per cycle, for request rounding.
// ----------------------------------------------------------------------------
module bwfa_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [bwfa_pkg::DIVD_W-1:0]  dividend,
    input  logic [bwfa_pkg::WB_W-1:0]    divisor,
    output logic [bwfa_pkg::DIVD_W-1:0]  quotient,
    output logic                         done
);

    logic                         busy_reg,  busy_next;
    logic                         done_reg,  done_next;
    logic [bwfa_pkg::STEP_W-1:0]  cnt_reg,   cnt_next;
    logic [bwfa_pkg::DIVD_W-1:0]  num_reg,   num_next;
    logic [bwfa_pkg::WB_W-1:0]    rem_reg,   rem_next;
    logic [bwfa_pkg::WB_W-1:0]    dvs_reg,   dvs_next;
    logic [bwfa_pkg::WB_W:0]      trial;
    logic                         ge;

    always_comb
    begin
        trial     = {rem_reg, num_reg[bwfa_pkg::DIVD_W-1]};
        ge        = trial >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = bwfa_pkg::STEP_W'(bwfa_pkg::DIV_STEPS - 1);
            num_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift one dividend bit in, subtract when it fits
            rem_next = ge ? bwfa_pkg::WB_W'(trial - {1'b0, dvs_reg})
                          : trial[bwfa_pkg::WB_W-1:0];
            num_next = {num_reg[bwfa_pkg::DIVD_W-2:0], ge};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = num_reg;
    assign done     = done_reg;

endmodule

>>> sv/bwfa_table.sv
// ----------------------------------------------------------------------------
// bwfa_table
// Segment table memory with its scan, shift and write-back sequencer.
// ----------------------------------------------------------------------------
module bwfa_table
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  bwfa_pkg::tbl_req_t          treq,
    input  logic                        init,
    input  logic [bwfa_pkg::LEN_W-1:0]  total_words,
    output bwfa_pkg::tbl_rsp_t          trsp
);

    typedef enum logic [7:0] {
        T_INIT  = 8'b0000_0001,
        T_IDLE  = 8'b0000_0010,
        T_SCAN  = 8'b0000_0100,
        T_FREE  = 8'b0000_1000,
        T_SHIFT = 8'b0001_0000,
        T_WRB   = 8'b0010_0000,
        T_WRA   = 8'b0100_0000,
        T_DONE  = 8'b1000_0000
    } tstate_t;

    localparam int IW = bwfa_pkg::IDX_W;
    localparam int CW = bwfa_pkg::CNT_W;
    localparam int LW = bwfa_pkg::LEN_W;
    localparam int OW = bwfa_pkg::OFF_W;

    tstate_t               state_reg,   state_next;
    logic [CW-1:0]         count_reg,   count_next;
    logic [CW-1:0]         cnt_new_reg, cnt_new_next;
    logic [CW-1:0]         ri_reg,      ri_next;
    logic [CW-1:0]         pi_reg,      pi_next;
    logic                  found_reg,   found_next;
    logic [IW-1:0]         best_reg,    best_next;
    logic [LW-1:0]         blen_reg,    blen_next;
    logic [OW-1:0]         bstart_reg,  bstart_next;
    bwfa_pkg::seg_t        prev_reg,    prev_next;
    bwfa_pkg::seg_t        cur_reg,     cur_next;
    logic                  cmd_reg,     cmd_next;
    logic [LW-1:0]         words_reg,   words_next;
    logic [OW-1:0]         off_reg,     off_next;
    logic                  fit_reg,     fit_next;
    logic [1:0]            status_reg,  status_next;
    logic [OW-1:0]         offset_reg,  offset_next;
    logic [CW-1:0]         sc_reg,      sc_next;
    logic [CW-1:0]         rem_reg,     rem_next;
    logic                  up_reg,      up_next;
    logic [1:0]            d_reg,       d_next;
    logic                  pv_reg,      pv_next;
    logic [IW-1:0]         pd_reg,      pd_next;
    logic [IW-1:0]         wa_addr_reg, wa_addr_next;
    bwfa_pkg::seg_t        wa_data_reg, wa_data_next;
    logic [IW-1:0]         wb_addr_reg, wb_addr_next;
    bwfa_pkg::seg_t        wb_data_reg, wb_data_next;
    logic                  wb_pend_reg, wb_pend_next;

    bwfa_pkg::seg_t        seg_mem_reg [bwfa_pkg::MAX_SEG];
    bwfa_pkg::seg_t        rd_data_reg;
    logic                  mem_we;
    logic [IW-1:0]         mem_wa;
    logic [IW-1:0]         mem_ra;
    bwfa_pkg::seg_t        mem_wd;

    always_comb
    begin
        logic           last;
        logic           hit;
        logic           better;
        logic           f_c;
        logic [IW-1:0]  bi_c;
        logic [LW-1:0]  bl_c;
        logic [OW-1:0]  bs_c;
        logic           pf;
        logic           nf;
        logic           nextv;
        logic [CW-1:0]  t_c;
        logic [1:0]     dd;
        bwfa_pkg::seg_t mrg;

        state_next   = state_reg;
        count_next   = count_reg;
        cnt_new_next = cnt_new_reg;
        ri_next      = ri_reg;
        pi_next      = pi_reg;
        found_next   = found_reg;
        best_next    = best_reg;
        blen_next    = blen_reg;
        bstart_next  = bstart_reg;
        prev_next    = prev_reg;
        cur_next     = cur_reg;
        cmd_next     = cmd_reg;
        words_next   = words_reg;
        off_next     = off_reg;
        fit_next     = fit_reg;
        status_next  = status_reg;
        offset_next  = offset_reg;
        sc_next      = sc_reg;
        rem_next     = rem_reg;
        up_next      = up_reg;
        d_next       = d_reg;
        pv_next      = pv_reg;
        pd_next      = pd_reg;
        wa_addr_next = wa_addr_reg;
        wa_data_next = wa_data_reg;
        wb_addr_next = wb_addr_reg;
        wb_data_next = wb_data_reg;
        wb_pend_next = wb_pend_reg;
        mem_we       = 1'b0;
        mem_wa       = '0;
        mem_wd       = '0;
        mem_ra       = ri_reg[IW-1:0];

        last   = (pi_reg == CW'(count_reg - 1'b1));
        hit    = !rd_data_reg.used && (rd_data_reg.len >= words_reg);
        better = !found_reg || (fit_reg ? (rd_data_reg.len > blen_reg)
                                        : (rd_data_reg.len < blen_reg));
        f_c    = found_reg;
        bi_c   = best_reg;
        bl_c   = blen_reg;
        bs_c   = bstart_reg;
        if (hit && better)
        begin
            f_c  = 1'b1;
            bi_c = pi_reg[IW-1:0];
            bl_c = rd_data_reg.len;
            bs_c = rd_data_reg.start;
        end

        nextv = (CW'(pi_reg + 1'b1) < count_reg);
        pf    = (pi_reg != '0) && !prev_reg.used;
        nf    = nextv && !rd_data_reg.used;
        t_c   = pi_reg;
        dd    = 2'd0;
        mrg   = cur_reg;
        mrg.used = 1'b0;
        if (pf && nf)
        begin
            t_c = CW'(pi_reg - 1'b1);
            dd  = 2'd2;
            mrg.start = prev_reg.start;
            mrg.len   = LW'(prev_reg.len + cur_reg.len + rd_data_reg.len);
        end
        else if (pf)
        begin
            t_c = CW'(pi_reg - 1'b1);
            dd  = 2'd1;
            mrg.start = prev_reg.start;
            mrg.len   = LW'(prev_reg.len + cur_reg.len);
        end
        else if (nf)
        begin
            dd  = 2'd1;
            mrg.len = LW'(cur_reg.len + rd_data_reg.len);
        end

        case (state_reg)
            T_INIT:
            begin
                mem_we     = 1'b1;
                mem_wa     = '0;
                mem_wd     = '{start: '0, len: total_words, used: 1'b0};
                count_next = CW'(1);
                state_next = T_IDLE;
            end
            T_IDLE:
            begin
                mem_ra = '0;
                if (init)
                begin
                    state_next = T_INIT;
                end
                else if (treq.start)
                begin
                    // entry 0 is read now, scan picks it up next cycle
                    cmd_next   = treq.cmd;
                    words_next = treq.words;
                    off_next   = treq.off;
                    fit_next   = treq.fit_mode;
                    ri_next    = CW'(1);
                    pi_next    = '0;
                    found_next = 1'b0;
                    state_next = T_SCAN;
                end
            end
            T_SCAN:
            begin
                ri_next = CW'(ri_reg + 1'b1);
                pi_next = CW'(pi_reg + 1'b1);
                if (cmd_reg == bwfa_pkg::CMD_ALLOC)
                begin
                    found_next  = f_c;
                    best_next   = bi_c;
                    blen_next   = bl_c;
                    bstart_next = bs_c;
                    if (last)
                    begin
                        offset_next  = '0;
                        pv_next      = 1'b0;
                        up_next      = 1'b1;
                        rem_next     = '0;
                        wa_addr_next = bi_c;
                        wa_data_next = '{start: bs_c, len: words_reg, used: 1'b1};
                        wb_pend_next = 1'b0;
                        cnt_new_next = count_reg;
                        if (!f_c)
                        begin
                            status_next = bwfa_pkg::ST_NOFIT;
                            state_next  = T_DONE;
                        end
                        else if (bl_c > words_reg)
                        begin
                            if (count_reg >= CW'(bwfa_pkg::MAX_SEG))
                            begin
                                status_next = bwfa_pkg::ST_FULL;
                                state_next  = T_DONE;
                            end
                            else
                            begin
                                // open a slot after the chosen hole
                                status_next  = bwfa_pkg::ST_OK;
                                offset_next  = bs_c;
                                rem_next     = CW'(count_reg - 1'b1 - {1'b0, bi_c});
                                sc_next      = CW'(count_reg - 1'b1);
                                wb_pend_next = 1'b1;
                                wb_addr_next = IW'(bi_c + 1'b1);
                                wb_data_next = '{start: OW'(bs_c + words_reg),
                                                 len:   LW'(bl_c - words_reg),
                                                 used:  1'b0};
                                cnt_new_next = CW'(count_reg + 1'b1);
                                state_next   = T_SHIFT;
                            end
                        end
                        else
                        begin
                            status_next = bwfa_pkg::ST_OK;
                            offset_next = bs_c;
                            state_next  = T_SHIFT;
                        end
                    end
                end
                else if (rd_data_reg.start == off_reg)
                begin
                    // the successor is being read this cycle
                    cur_next   = rd_data_reg;
                    pi_next    = pi_reg;
                    state_next = T_FREE;
                end
                else
                begin
                    prev_next = rd_data_reg;
                    if (last)
                    begin
                        status_next = bwfa_pkg::ST_NOT_FOUND;
                        offset_next = '0;
                        state_next  = T_DONE;
                    end
                end
            end
            T_FREE:
            begin
                status_next  = bwfa_pkg::ST_OK;
                offset_next  = '0;
                up_next      = 1'b0;
                d_next       = dd;
                pv_next      = 1'b0;
                rem_next     = CW'(count_reg - t_c - 1'b1 - {{(CW-2){1'b0}}, dd});
                sc_next      = CW'(t_c + 1'b1 + {{(CW-2){1'b0}}, dd});
                wa_addr_next = t_c[IW-1:0];
                wa_data_next = mrg;
                wb_pend_next = 1'b0;
                cnt_new_next = CW'(count_reg - {{(CW-2){1'b0}}, dd});
                state_next   = T_SHIFT;
            end
            T_SHIFT:
            begin
                mem_ra = sc_reg[IW-1:0];
                if (pv_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = pd_reg;
                    mem_wd = rd_data_reg;
                end
                if (rem_reg != '0)
                begin
                    pv_next  = 1'b1;
                    pd_next  = up_reg ? IW'(sc_reg + 1'b1)
                                      : IW'(sc_reg - {{(CW-2){1'b0}}, d_reg});
                    sc_next  = up_reg ? CW'(sc_reg - 1'b1) : CW'(sc_reg + 1'b1);
                    rem_next = CW'(rem_reg - 1'b1);
                end
                else
                begin
                    pv_next = 1'b0;
                    if (!pv_reg)
                    begin
                        state_next = wb_pend_reg ? T_WRB : T_WRA;
                    end
                end
            end
            T_WRB:
            begin
                mem_we     = 1'b1;
                mem_wa     = wb_addr_reg;
                mem_wd     = wb_data_reg;
                state_next = T_WRA;
            end
            T_WRA:
            begin
                mem_we     = 1'b1;
                mem_wa     = wa_addr_reg;
                mem_wd     = wa_data_reg;
                count_next = cnt_new_reg;
                state_next = T_DONE;
            end
            T_DONE:
            begin
                state_next = T_IDLE;
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_INIT;
            count_reg <= CW'(1);
            pv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pv_reg    <= pv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_new_reg <= cnt_new_next;
        ri_reg      <= ri_next;
        pi_reg      <= pi_next;
        found_reg   <= found_next;
        best_reg    <= best_next;
        blen_reg    <= blen_next;
        bstart_reg  <= bstart_next;
        prev_reg    <= prev_next;
        cur_reg     <= cur_next;
        cmd_reg     <= cmd_next;
        words_reg   <= words_next;
        off_reg     <= off_next;
        fit_reg     <= fit_next;
        status_reg  <= status_next;
        offset_reg  <= offset_next;
        sc_reg      <= sc_next;
        rem_reg     <= rem_next;
        up_reg      <= up_next;
        d_reg       <= d_next;
        pd_reg      <= pd_next;
        wa_addr_reg <= wa_addr_next;
        wa_data_reg <= wa_data_next;
        wb_addr_reg <= wb_addr_next;
        wb_data_reg <= wb_data_next;
        wb_pend_reg <= wb_pend_next;
    end

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            seg_mem_reg[mem_wa] <= mem_wd;
        end
        rd_data_reg <= seg_mem_reg[mem_ra];
    end

    assign trsp.busy   = (state_reg != T_IDLE);
    assign trsp.done   = (state_reg == T_DONE);
    assign trsp.status = status_reg;
    assign trsp.offset = offset_reg;

    a_shift_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_SHIFT && mem_we) |-> (mem_wa != mem_ra))
        else $error("shift writes the entry it reads");

    a_count_update: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
        ($past(state_reg) == T_WRA || $past(state_reg) == T_INIT))
        else $error("segment count changed outside write-back");

    a_start_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_IDLE && treq.start && !init) |=> (state_reg == T_SCAN))
        else $error("request not taken by idle table");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_WRA) |-> (cnt_new_reg != '0 &&
        cnt_new_reg <= CW'(bwfa_pkg::MAX_SEG)))
        else $error("segment count out of range");

endmodule

>>> sv/best_worst_fit_segment_allocator_core.sv
// ----------------------------------------------------------------------------
// best_worst_fit_segment_allocator_core
// Segment allocator: best or worst fit allocation, free with neighbor merge.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) carries one command word:
//   allocate a byte count, or free the segment starting at a word offset.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns one word per command:
//   status and, for a good allocate, the segment's word offset.
//   The APB port sets word_bytes, total_words and fit_mode; writing a valid
//   total_words while the table is idle resets it to one free hole.
// Sequence:
//   Allocate: a rounding divide, then a scan of every table entry, then a
//   move of the entries after the chosen hole to open a slot, then the
//   write-back; the table holds up to 64 entries.
//   Free: scan up to the match, then a move of entries down to close the
//   gap. The table memory, with one read and one write port, sets this.
//   One command is worked at a time; req_stall is high while it runs.
// Reset: the table holds one free hole of 65536 words, after one init cycle.
// The result sits in an output register; while rsp_stall is high it holds,
// and the next command may already be accepted and worked.
// ----------------------------------------------------------------------------
module best_worst_fit_segment_allocator_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  bwfa_pkg::req_t                req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output bwfa_pkg::rsp_t                rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bwfa_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_TBL  = 4'b0100,
        S_RES  = 4'b1000
    } state_t;

    localparam int LW = bwfa_pkg::LEN_W;
    localparam int OW = bwfa_pkg::OFF_W;

    state_t                          state_reg,  state_next;
    logic [bwfa_pkg::WB_W-1:0]       wbytes_reg;
    logic [LW-1:0]                   twords_reg;
    logic                            fit_reg;
    logic                            cmd_reg,    cmd_next;
    logic [OW-1:0]                   off_reg,    off_next;
    logic [LW-1:0]                   words_reg,  words_next;
    logic                            tstart_reg, tstart_next;
    bwfa_pkg::rsp_t                  res_reg,    res_next;
    logic                            rsp_valid_reg;
    bwfa_pkg::rsp_t                  rsp_reg;

    logic                            cfg_wr;
    logic                            tw_ok;
    logic                            init_tbl;
    logic [bwfa_pkg::WB_W-1:0]       wb_eff;
    logic [bwfa_pkg::DIVD_W-1:0]     limit;
    logic                            bad;
    logic                            accept;
    logic                            div_start;
    logic [bwfa_pkg::DIVD_W-1:0]     dividend;
    logic [bwfa_pkg::DIVD_W-1:0]     quotient;
    logic                            div_done;
    logic                            out_free;
    bwfa_pkg::tbl_req_t              treq;
    bwfa_pkg::tbl_rsp_t              trsp;

    // ---- configuration registers ----
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign tw_ok    = (pwdata[LW-1:0] != '0) && (pwdata[LW-1:0] <= bwfa_pkg::WORD_LIMIT);
    assign init_tbl = cfg_wr && (paddr[3:2] == bwfa_pkg::REG_TOTAL_WORDS) && tw_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wbytes_reg <= bwfa_pkg::WB_W'(1);
            twords_reg <= bwfa_pkg::WORD_LIMIT;
            fit_reg    <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                bwfa_pkg::REG_WORD_BYTES:  wbytes_reg <= pwdata[bwfa_pkg::WB_W-1:0];
                bwfa_pkg::REG_TOTAL_WORDS:
                begin
                    if (tw_ok)
                    begin
                        twords_reg <= pwdata[LW-1:0];
                    end
                end
                bwfa_pkg::REG_FIT_MODE:    fit_reg <= pwdata[0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            bwfa_pkg::REG_WORD_BYTES:  prdata = {{(32-bwfa_pkg::WB_W){1'b0}}, wbytes_reg};
            bwfa_pkg::REG_TOTAL_WORDS: prdata = {{(32-LW){1'b0}}, twords_reg};
            bwfa_pkg::REG_FIT_MODE:    prdata = {31'd0, fit_reg};
            default:                   prdata = '0;
        endcase
    end

    // ---- request check and rounding ----
    // a word size of zero counts as one
    assign wb_eff   = (wbytes_reg == '0) ? bwfa_pkg::WB_W'(1) : wbytes_reg;
    assign limit    = bwfa_pkg::DIVD_W'(twords_reg * wb_eff);
    assign bad      = (req.size_bytes == '0) ||
                      ({1'b0, req.size_bytes} > limit);
    assign dividend = bwfa_pkg::DIVD_W'({1'b0, req.size_bytes} + wb_eff - 1'b1);

    assign req_stall = (state_reg != S_IDLE) || trsp.busy;
    assign accept    = req_valid && !req_stall;
    assign div_start = accept && (req.cmd == bwfa_pkg::CMD_ALLOC) && !bad;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    bwfa_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (wb_eff),
        .quotient (quotient),
        .done     (div_done)
    );

    assign treq.start    = tstart_reg;
    assign treq.cmd      = cmd_reg;
    assign treq.words    = words_reg;
    assign treq.off      = off_reg;
    assign treq.fit_mode = fit_reg;

    bwfa_table u_table
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .treq        (treq),
        .init        (init_tbl),
        .total_words (twords_reg),
        .trsp        (trsp)
    );

    // ---- command sequencing ----
    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        off_next    = off_reg;
        words_next  = words_reg;
        tstart_next = 1'b0;
        res_next    = res_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = req.cmd;
                    off_next = req.offset_words;
                    if (req.cmd == bwfa_pkg::CMD_FREE)
                    begin
                        tstart_next = 1'b1;
                        state_next  = S_TBL;
                    end
                    else if (bad)
                    begin
                        // zero or oversize request: answer without the table
                        res_next   = '{status: bwfa_pkg::ST_NOFIT, result_offset: '0};
                        state_next = S_RES;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    words_next  = quotient[LW-1:0];
                    tstart_next = 1'b1;
                    state_next  = S_TBL;
                end
            end
            S_TBL:
            begin
                if (trsp.done)
                begin
                    res_next   = '{status: trsp.status, result_offset: trsp.offset};
                    state_next = S_RES;
                end
            end
            S_RES:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tstart_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            tstart_reg <= tstart_next;
            // load the output word when free, drop valid once taken
            if (state_reg == S_RES && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        off_reg   <= off_next;
        words_reg <= words_next;
        res_reg   <= res_next;
        if (state_reg == S_RES && out_free)
        begin
            rsp_reg <= res_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
